/* rtl/core/fit_partition_allocator_unit_defines.svh */
// Assertion macros for the partition allocator checker.
`ifndef FIT_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
`define FIT_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FPA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define FPA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/fpa_pkg.sv */
// Shared types and constants of the partition allocator.
package fpa_pkg;

   localparam int INDEX_W    = 4;
   localparam int VALUE_W    = 16;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   // placement rules: smallest fitting size, lowest fitting index, largest fitting size
   localparam logic [1:0] MODE_SMALLEST = 2'd0;
   localparam logic [1:0] MODE_LOWEST   = 2'd1;
   localparam logic [1:0] MODE_LARGEST  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_FIT_MODE      = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLOCKS_IN_USE = 1'b1;

   localparam logic [1:0] FIT_MODE_RESET = MODE_SMALLEST;
   localparam logic [4:0] BLOCKS_RESET   = 5'd16;

   typedef struct packed {
      logic               func;
      logic [INDEX_W-1:0] part_index;
      logic [VALUE_W-1:0] size_value;
   } req_type;

   typedef struct packed {
      logic               granted;
      logic [INDEX_W-1:0] chosen_index;
      logic [VALUE_W-1:0] remaining_size;
   } rsp_type;

   typedef struct packed {
      logic [1:0] fit_mode;
      logic [4:0] blocks_in_use;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

endpackage

/* rtl/core/fpa_ram.sv */
// Generic simple dual-port RAM with registered read.
module fpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/fpa_scan.sv */
// Scan sequencer with one shared compare unit and charge writeback.
module fpa_scan
   import fpa_pkg::*;
#(
   parameter int PARTITIONS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  req_type                       req_data,
   input  cfg_type                       cfg,
   output logic                          busy,
   output logic                          rsp_valid,
   output rsp_type                       rsp_data,
   output logic                          ram_we,
   output logic [$clog2(PARTITIONS)-1:0] ram_waddr,
   output logic [SIZE_BITS-1:0]          ram_wdata,
   output logic                          ram_re,
   output logic [$clog2(PARTITIONS)-1:0] ram_raddr,
   input  logic [SIZE_BITS-1:0]          ram_rdata
);

   localparam int IDX_W = $clog2(PARTITIONS);
   localparam int CNT_W = $clog2(PARTITIONS + 1);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic [1:0]            mode_ff, mode_in;
   logic [SIZE_BITS-1:0]  size_ff, size_in;
   logic                  rdv_ff, rdv_in;
   logic [IDX_W-1:0]      ridx_ff, ridx_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0]  best_val_ff, best_val_in;
   logic [PARTITIONS-1:0] valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic                  load_ok;
   logic                  mode_ok;
   logic [CNT_W-1:0]      lim_calc;
   logic                  last_data;
   logic [SIZE_BITS-1:0]  cur;
   logic                  take;
   logic [SIZE_BITS-1:0]  rem;

   assign accept   = start && (state_ff == ST_IDLE);
   assign load_ok  = (32'(req_data.part_index) < 32'(PARTITIONS));
   assign mode_ok  = (cfg.fit_mode == MODE_SMALLEST) || (cfg.fit_mode == MODE_LOWEST) ||
                     (cfg.fit_mode == MODE_LARGEST);
   assign lim_calc = (32'(cfg.blocks_in_use) > 32'(PARTITIONS)) ?
                     CNT_W'(PARTITIONS) : CNT_W'(cfg.blocks_in_use);
   assign last_data = rdv_ff && (ridx_ff == IDX_W'(limit_ff - CNT_W'(1)));

   // never-written entries read as zero
   assign cur  = valid_ff[ridx_ff] ? ram_rdata : '0;
   assign take = (cur >= size_ff) &&
                 (!found_ff ||
                  ((mode_ff == MODE_SMALLEST) && (cur < best_val_ff)) ||
                  ((mode_ff == MODE_LARGEST) && (cur > best_val_ff)));
   assign rem  = best_val_ff - size_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.func == FUNC_ALLOC)) begin
               state_in = (mode_ok && (lim_calc != '0)) ? ST_SCAN : ST_WRITE;
            end
         end
         ST_SCAN: begin
            if (last_data) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // FSM outputs: RAM control
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      ram_re    = 1'b0;
      ram_raddr = cnt_ff[IDX_W-1:0];
      ram_we    = 1'b0;
      ram_waddr = IDX_W'(req_data.part_index);
      ram_wdata = SIZE_BITS'(req_data.size_value);
      unique case (state_ff)
         ST_IDLE: begin
            ram_we = accept && (req_data.func == FUNC_LOAD) && load_ok;
         end
         ST_SCAN: begin
            ram_re = (cnt_ff < limit_ff);
         end
         ST_WRITE: begin
            ram_we    = found_ff;
            ram_waddr = best_idx_ff;
            ram_wdata = rem;
         end
         default: begin
            ram_re = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      cnt_in       = cnt_ff;
      limit_in     = limit_ff;
      mode_in      = mode_ff;
      size_in      = size_ff;
      rdv_in       = 1'b0;
      ridx_in      = ridx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (ram_we) begin
         valid_in[ram_waddr] = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.func == FUNC_ALLOC)) begin
               limit_in    = lim_calc;
               mode_in     = cfg.fit_mode;
               size_in     = SIZE_BITS'(req_data.size_value);
               cnt_in      = '0;
               found_in    = 1'b0;
               best_idx_in = '0;
               best_val_in = '0;
            end
         end
         ST_SCAN: begin
            rdv_in  = ram_re;
            ridx_in = cnt_ff[IDX_W-1:0];
            if (ram_re) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (rdv_ff && take) begin
               found_in    = 1'b1;
               best_idx_in = ridx_ff;
               best_val_in = cur;
            end
         end
         ST_WRITE: begin
            rsp_valid_in          = 1'b1;
            rsp_in.granted        = found_ff;
            rsp_in.chosen_index   = found_ff ? INDEX_W'(best_idx_ff) : '0;
            rsp_in.remaining_size = found_ff ? VALUE_W'(rem) : '0;
         end
         default: begin
            rdv_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rdv_ff       <= 1'b0;
         found_ff     <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rdv_ff       <= rdv_in;
         found_ff     <= found_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      limit_ff    <= limit_in;
      mode_ff     <= mode_in;
      size_ff     <= size_in;
      ridx_ff     <= ridx_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/fit_partition_allocator_unit.sv */
// Load: a load request is absorbed in its accept cycle; busy stays low, no response.
// Allocate: ST_SCAN reads L = min(blocks_in_use, PARTITIONS) entries, ST_WRITE charges
// the pick, then the registered response strobes; ST_SCAN is skipped when the mode code
// is unused or L is zero. One compare unit takes one partition per cycle from the RAM
// read port. busy drops with the strobe, so the next request can be taken with it.
// Reset (sync, high): table all zero via valid bits, best fit, 16 in use; no rsp stall.
module fit_partition_allocator_unit
   import fpa_pkg::*;
#(
   parameter int PARTITIONS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(PARTITIONS);

   // configuration registers
   logic [1:0] fit_mode_ff, fit_mode_in;
   logic [4:0] blocks_ff, blocks_in;
   cfg_type    cfg;

   always_comb begin
      fit_mode_in = fit_mode_ff;
      blocks_in   = blocks_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_FIT_MODE: begin
               fit_mode_in = csr_wdata[1:0];
            end
            CSR_BLOCKS_IN_USE: begin
               blocks_in = csr_wdata;
            end
            default: begin
               fit_mode_in = fit_mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= FIT_MODE_RESET;
         blocks_ff   <= BLOCKS_RESET;
      end else begin
         fit_mode_ff <= fit_mode_in;
         blocks_ff   <= blocks_in;
      end
   end

   assign cfg.fit_mode      = fit_mode_ff;
   assign cfg.blocks_in_use = blocks_ff;

   // free-size table
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [SIZE_BITS-1:0] ram_wdata;
   logic                 ram_re;
   logic [IDX_W-1:0]     ram_raddr;
   logic [SIZE_BITS-1:0] ram_rdata;

   fpa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (PARTITIONS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // scan sequencer: compare one entry per cycle, then charge the pick
   fpa_scan #(
      .PARTITIONS (PARTITIONS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .cfg       (cfg),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

endmodule

/* rtl/core/fpa_checker.sv */
// Port-level checks of the partition allocator, bound to the top level.
`include "fit_partition_allocator_unit_defines.svh"

module fpa_checker
   import fpa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic take_load;
   logic take_alloc;
   logic denied;
   logic deny_clean;

   assign take_load  = start && !busy && (req_data.func == FUNC_LOAD);
   assign take_alloc = start && !busy && (req_data.func == FUNC_ALLOC);
   assign denied     = rsp_valid && !rsp_data.granted;
   assign deny_clean = (rsp_data.chosen_index == '0) && (rsp_data.remaining_size == '0);

   `FPA_ASSERT_IMP(a_rsp_when_idle, rsp_valid, !busy, "response strobe while busy")
   `FPA_ASSERT_NXT(a_load_silent, take_load, !busy && !rsp_valid, "load went busy or answered")
   `FPA_ASSERT_NXT(a_alloc_busy, take_alloc, busy, "allocate request did not go busy")
   `FPA_ASSERT_NXT(a_single_strobe, rsp_valid, !rsp_valid, "response strobe too long")
   `FPA_ASSERT_IMP(a_deny_zero, denied, deny_clean, "denied response not zeroed")

endmodule

bind fit_partition_allocator_unit fpa_checker u_fpa_checker (.*);

/* verif/fpa_grant_checker.sv */
// Allocator channel monitor: predicts each allocate response and compares it.
`timescale 1ns / 100ps
module fpa_grant_checker
   import fpa_pkg::*;
#(
   parameter int PARTITIONS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   logic [VALUE_W-1:0] free_tbl [PARTITIONS];
   logic [1:0]         mode_q;
   logic [4:0]         blocks_q;
   rsp_type            grant_q [$];
   int                 errors;

   initial begin
      errors        = 0;
      fail_count    = 0;
      pending_count = 0;
   end

   // Apply one accepted request to the shadow table; allocates queue a grant.
   task automatic place_request(input req_type r);
      int      scan_len;
      int      pick;
      logic    found;
      rsp_type g;
      if (r.func == FUNC_LOAD) begin
         if (r.part_index < PARTITIONS) free_tbl[r.part_index] = r.size_value;
         return;
      end
      scan_len = (blocks_q > PARTITIONS) ? PARTITIONS : blocks_q;
      found    = 1'b0;
      pick     = 0;
      // unused mode code scans nothing
      if (mode_q == MODE_SMALLEST || mode_q == MODE_LOWEST || mode_q == MODE_LARGEST) begin
         for (int j = 0; j < scan_len; j++) begin
            if (free_tbl[j] >= r.size_value) begin
               if (!found) begin
                  found = 1'b1;
                  pick  = j;
               end else if (mode_q == MODE_SMALLEST && free_tbl[j] < free_tbl[pick]) begin
                  pick = j;
               end else if (mode_q == MODE_LARGEST && free_tbl[j] > free_tbl[pick]) begin
                  pick = j;
               end
            end
         end
      end
      g = '0;
      if (found) begin
         free_tbl[pick]   = free_tbl[pick] - r.size_value;
         g.granted        = 1'b1;
         g.chosen_index   = pick[INDEX_W-1:0];
         g.remaining_size = free_tbl[pick];
      end
      grant_q.push_back(g);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int k = 0; k < PARTITIONS; k++) free_tbl[k] = '0;
         mode_q   = FIT_MODE_RESET;
         blocks_q = BLOCKS_RESET;
         grant_q.delete();
      end else begin
         if (rsp_valid) begin
            if (grant_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response with none expected: granted=%0b idx=%0d rem=%0d",
                           $realtime, rsp_data.granted, rsp_data.chosen_index,
                           rsp_data.remaining_size);
            end else begin
               want = grant_q.pop_front();
               if (rsp_data.granted !== want.granted ||
                   rsp_data.chosen_index !== want.chosen_index ||
                   rsp_data.remaining_size !== want.remaining_size) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch exp granted=%0b idx=%0d rem=%0d, got %0b %0d %0d",
                              $realtime, want.granted, want.chosen_index,
                              want.remaining_size, rsp_data.granted,
                              rsp_data.chosen_index, rsp_data.remaining_size);
               end
            end
         end
         if (csr_we) begin
            if (csr_addr == CSR_FIT_MODE) mode_q = csr_wdata[1:0];
            else if (csr_addr == CSR_BLOCKS_IN_USE) blocks_q = csr_wdata[4:0];
         end
         if (start && !busy) place_request(req_data);
      end
      fail_count    <= errors;
      pending_count <= grant_q.size();
   end

endmodule

/* verif/tb_top.sv */
// Top of the partition allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
   import fpa_pkg::*;

   // Mode code that matches no placement rule.
   localparam logic [1:0] FIT_UNUSED = 2'd3;

   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 67;
   // Settle time, well beyond a full scan from accept to response.
   localparam int SETTLE_CYCLES   = 30;
   // Worst quiet stretch is a long gap plus a full scan, or the settle wait.
   localparam int IDLE_LIMIT      = 2000;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   req_type               req_data  = '0;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  busy;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   int                    fail_count;
   int                    pending_count;
   int                    idle_cycles = 0;
   // when set, the current phase runs back to back with no gaps
   logic                  quiet = 1'b0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   fit_partition_allocator_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   fpa_grant_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Watchdog: any request, response or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Present one request and hold it until the block takes it. Returns on the
   // accepting edge with start still high, so a following request can go
   // straight out without a dead cycle.
   task automatic send_request(input logic func, input logic [INDEX_W-1:0] idx,
                               input logic [VALUE_W-1:0] size);
      req_type r;
      r.func       = func;
      r.part_index = idx;
      r.size_value = size;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int gap_len();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Loads lean toward large sizes, allocates toward small requests, so the
   // table neither stays empty nor fills up; extremes show up in both.
   function automatic logic [VALUE_W-1:0] pick_size(input logic func);
      logic [VALUE_W-1:0] v;
      if (func == FUNC_LOAD) begin
         case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            2, 3:    v = VALUE_W'($urandom_range(0, 4095));
            default: v = VALUE_W'($urandom);
         endcase
      end else begin
         case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            2:       v = VALUE_W'($urandom);
            3:       v = VALUE_W'($urandom_range(0, 4095));
            default: v = VALUE_W'($urandom_range(1, 255));
         endcase
      end
      return v;
   endfunction

   // Registers change only with the block idle: drain all responses, let any
   // scan in flight finish, then write mode and scan length back to back.
   // Upper data bits of the mode write are junk; only the low two count.
   task automatic set_config(input logic [1:0] mode, input logic [4:0] blocks);
      logic [2:0] junk;
      junk  = 3'($urandom_range(0, 7));
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_FIT_MODE;
      csr_wdata <= {junk, mode};
      @(posedge clock);
      csr_addr  <= CSR_BLOCKS_IN_USE;
      csr_wdata <= blocks;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [1:0] mode;
      logic [4:0] blocks;
      logic       func;
      int         r;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part, reset config: best fit over all 16 partitions ----
      // zero request on a freshly cleared table: partition 0, size stays 0
      send_request(FUNC_ALLOC, 4'd15, 16'd0);
      send_request(FUNC_LOAD,  4'd0,  16'hFFFF);
      send_request(FUNC_LOAD,  4'd15, 16'd100);
      send_request(FUNC_LOAD,  4'd5,  16'd100);
      send_request(FUNC_LOAD,  4'd7,  16'd300);
      send_request(FUNC_LOAD,  4'd9,  16'h8000);
      // exact-fit tie between 5 and 15: lowest index wins
      send_request(FUNC_ALLOC, 4'd0,  16'd100);
      // largest request drains the full partition
      send_request(FUNC_ALLOC, 4'd3,  16'hFFFF);
      send_request(FUNC_ALLOC, 4'd10, 16'd200);
      // nothing large enough: not granted, fields zero
      send_request(FUNC_ALLOC, 4'd6,  16'hFFFF);

      // first fit, scan length above the partition count saturates
      set_config(MODE_LOWEST, 5'd31);
      send_request(FUNC_ALLOC, 4'd1,  16'd50);
      send_request(FUNC_ALLOC, 4'd2,  16'd0);

      // worst fit; a zero request lands on the largest and leaves it as is
      set_config(MODE_LARGEST, 5'd16);
      send_request(FUNC_ALLOC, 4'd0,  16'd1);
      send_request(FUNC_LOAD,  4'd3,  16'hFFFF);
      send_request(FUNC_ALLOC, 4'd8,  16'd0);

      // unused mode code: never granted, table untouched
      set_config(FIT_UNUSED, 5'd16);
      send_request(FUNC_ALLOC, 4'd0,  16'd0);
      send_request(FUNC_ALLOC, 4'd0,  16'd1);

      // empty scan: never granted
      set_config(MODE_SMALLEST, 5'd0);
      send_request(FUNC_ALLOC, 4'd4,  16'd0);

      // single partition scanned
      set_config(MODE_LARGEST, 5'd1);
      send_request(FUNC_ALLOC, 4'd12, 16'd0);
      send_request(FUNC_ALLOC, 4'd12, 16'd1);

      // ---- random part: fixed corner settings first, then random ones ----
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin mode = MODE_SMALLEST; blocks = 5'd16; end
            1: begin mode = MODE_LOWEST;   blocks = 5'd31; end
            2: begin mode = MODE_LARGEST;  blocks = 5'd0;  end
            3: begin mode = FIT_UNUSED;    blocks = 5'd16; end
            4: begin mode = MODE_LARGEST;  blocks = 5'd16; end
            5: begin mode = MODE_SMALLEST; blocks = 5'd1;  end
            6: begin mode = MODE_LOWEST;   blocks = 5'd16; end
            7: begin mode = MODE_SMALLEST; blocks = 5'd17; end
            default: begin
               r = $urandom_range(0, 9);
               mode = (r < 3) ? MODE_SMALLEST : (r < 6) ? MODE_LOWEST :
                      (r < 9) ? MODE_LARGEST : FIT_UNUSED;
               r = $urandom_range(0, 9);
               blocks = (r == 0) ? 5'd0 :
                        (r == 1) ? 5'($urandom_range(17, 31)) :
                                   5'($urandom_range(1, 16));
            end
         endcase
         set_config(mode, blocks);
         quiet = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            func = ($urandom_range(0, 9) < 4) ? FUNC_LOAD : FUNC_ALLOC;
            send_request(func, 4'($urandom), pick_size(func));
            pause(gap_len());
         end
      end

      // drain: all responses in, then a margin for anything stray
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

endmodule
